@@ hw/rtl/two_body_gravity_step_unit_assert.svh @@
// Assertion macros for the two-body gravity step unit.
// Users must have clk and rst_n in scope; rst_n low disables the check.
`ifndef TWO_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH
`define TWO_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TGS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tgs_pkg.sv @@
// Package for the two-body gravity step unit: widths, codes, states, control structs.
// No dependencies.
`timescale 1ns / 1ps

package tgs_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 30;
  localparam int POS_W     = 32;
  localparam int ACC_W     = 48;
  localparam int DT_W      = 16;
  localparam int GC_W      = 24;
  localparam int MASS_W    = 20;
  localparam int LIM_W     = 16;

  // Intermediate widths
  localparam int DIFF_W = POS_W + 1;              // offset and its magnitude
  localparam int SQ_W   = 2 * DIFF_W;             // squared distance
  localparam int ROOT_W = DIFF_W;                 // floor sqrt
  localparam int K_W    = GC_W + MASS_W;          // G * mass
  localparam int G_W    = K_W + 2 * FRAC_BITS;    // pull dividend / quotient
  localparam int UNIT_W = UNIT_BITS + 1;          // unit vector component
  localparam int ENG_W  = G_W + UNIT_W + 1;       // engine accumulator
  localparam int ENGB_W = SQ_W;                   // divisor / multiplier operand
  localparam int REM_W  = ENGB_W + 2;             // remainder register
  localparam int CNT_W  = 7;                      // iteration counter

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_FIRST  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_SECOND = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 8'd3;

  localparam logic [GC_W-1:0]   GRAV_RESET  = 24'd100000;
  localparam logic [MASS_W-1:0] MASS_RESET  = 20'd1000;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 16'd6554;

  // Input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } eng_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_RSQ,
    ST_K0, ST_G0, ST_K1, ST_G1,
    ST_UX, ST_UY,
    ST_AX0, ST_AY0, ST_AX1, ST_AY1,
    ST_VX0, ST_VY0, ST_PX0, ST_PY0,
    ST_VX1, ST_VY1, ST_PX1, ST_PY1,
    ST_RESULT
  } step_t;

  // Sequencer to datapath
  typedef struct packed {
    logic             start;
    eng_op_t          op;
    logic [CNT_W-1:0] iters;
    step_t            step;
    logic             wb;
    logic             in_ready;
    logic             out_valid;
  } seq_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic accept;
    logic is_step;
    logic coincident;
    logic integrate;
    logic eng_done;
    logic out_ready;
  } seq_stat_t;

endpackage

@@ hw/rtl/tgs_ifs.sv @@
// Channel interfaces: item input, result output and configuration write.
// Depends on tgs_pkg.
`timescale 1ns / 1ps

interface tgs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic                             body_select;
  logic signed [tgs_pkg::POS_W-1:0] load_pos_x;
  logic signed [tgs_pkg::POS_W-1:0] load_pos_y;
  logic signed [tgs_pkg::POS_W-1:0] load_vel_x;
  logic signed [tgs_pkg::POS_W-1:0] load_vel_y;
  logic signed [tgs_pkg::ACC_W-1:0] load_acc_x;
  logic signed [tgs_pkg::ACC_W-1:0] load_acc_y;
  logic        [tgs_pkg::DT_W-1:0]  time_step;

  modport source (output valid, command, body_select, load_pos_x, load_pos_y,
                  load_vel_x, load_vel_y, load_acc_x, load_acc_y, time_step,
                  input ready);
  modport sink (input valid, command, body_select, load_pos_x, load_pos_y,
                load_vel_x, load_vel_y, load_acc_x, load_acc_y, time_step,
                output ready);
endinterface

interface tgs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tgs_pkg::POS_W-1:0] first_x;
  logic signed [tgs_pkg::POS_W-1:0] first_y;
  logic signed [tgs_pkg::POS_W-1:0] second_x;
  logic signed [tgs_pkg::POS_W-1:0] second_y;
  logic                             coincident;
  logic                             integrated;
  logic                             saturated;

  modport source (output valid, first_x, first_y, second_x, second_y, coincident,
                  integrated, saturated, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, coincident,
                integrated, saturated, output ready);
endinterface

interface tgs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tgs_pkg::CFG_IDX_W-1:0]     index;
  logic [tgs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tgs_engine.sv @@
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, bit-pair sqrt.
// One bit (two radicand bits for sqrt) per cycle. Depends on tgs_pkg.
`timescale 1ns / 1ps

module tgs_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  tgs_pkg::eng_op_t             op,
  input  logic [tgs_pkg::CNT_W-1:0]    iters,
  input  logic [tgs_pkg::ENG_W-1:0]    a_in,
  input  logic [tgs_pkg::ENGB_W-1:0]   b_in,
  output logic                         busy,
  output logic                         done,
  output logic [tgs_pkg::ENG_W-1:0]    result
);

  localparam int EW = tgs_pkg::ENG_W;
  localparam int BW = tgs_pkg::ENGB_W;
  localparam int RW = tgs_pkg::REM_W;
  localparam int QW = tgs_pkg::G_W;
  localparam int SW = tgs_pkg::SQ_W;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  tgs_pkg::eng_op_t          op_r, op_nxt;
  logic [tgs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0]             a_r, a_nxt;
  logic [BW-1:0]             b_r, b_nxt;
  logic [EW-1:0]             acc_r, acc_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;

  logic [RW-1:0] div_rem, div_diff, sq_rem, sq_trial, sq_diff;
  logic          div_ge, sq_ge;
  logic [EW-1:0] mul_sum;

  // One step of each operation
  always_comb begin
    div_rem  = {rem_r[RW-2:0], a_r[QW-1]};
    div_ge   = (div_rem >= {2'b00, b_r});
    div_diff = div_rem - {2'b00, b_r};
    sq_rem   = {rem_r[RW-3:0], a_r[SW-1:SW-2]};
    sq_trial = {acc_r[RW-3:0], 2'b01};
    sq_ge    = (sq_rem >= sq_trial);
    sq_diff  = sq_rem - sq_trial;
    mul_sum  = acc_r + (b_r[0] ? a_r : '0);
  end

  // Iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        op_nxt   = op;
        cnt_nxt  = iters;
        a_nxt    = a_in;
        b_nxt    = b_in;
        acc_nxt  = '0;
        rem_nxt  = '0;
      end
    end else begin
      case (op_r)
        tgs_pkg::OP_MUL: begin
          acc_nxt = mul_sum;
          a_nxt   = {a_r[EW-2:0], 1'b0};
          b_nxt   = {1'b0, b_r[BW-1:1]};
        end
        tgs_pkg::OP_DIV: begin
          rem_nxt       = div_ge ? div_diff : div_rem;
          a_nxt[QW-1:0] = {a_r[QW-2:0], div_ge};
        end
        tgs_pkg::OP_SQRT: begin
          rem_nxt = sq_ge ? sq_diff : sq_rem;
          acc_nxt = {acc_r[EW-2:0], sq_ge};
          a_nxt   = {a_r[EW-3:0], 2'b00};
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tgs_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= tgs_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  // Result select
  always_comb begin
    case (op_r)
      tgs_pkg::OP_DIV: result = {{(EW-QW){1'b0}}, a_r[QW-1:0]};
      default:         result = acc_r;
    endcase
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

@@ hw/rtl/tgs_seq.sv @@
// Sequencer: walks the operation list of a step through the shared engine.
// Depends on tgs_pkg.
`timescale 1ns / 1ps

module tgs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tgs_pkg::seq_stat_t  stat,
  output tgs_pkg::seq_ctrl_t  ctrl
);

  tgs_pkg::step_t state_r, state_nxt;
  logic           issued_r, issued_nxt;
  logic           is_op;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgs_pkg::ST_IDLE: begin
        if (stat.accept) begin
          if (!stat.is_step)        state_nxt = tgs_pkg::ST_RESULT;
          else if (!stat.coincident) state_nxt = tgs_pkg::ST_SQ_X;
          else if (stat.integrate)  state_nxt = tgs_pkg::ST_VX0;
          else                      state_nxt = tgs_pkg::ST_RESULT;
        end
      end
      tgs_pkg::ST_RESULT: if (stat.out_ready) state_nxt = tgs_pkg::ST_IDLE;
      tgs_pkg::ST_AY1: begin
        if (stat.eng_done)
          state_nxt = stat.integrate ? tgs_pkg::ST_VX0 : tgs_pkg::ST_RESULT;
      end
      tgs_pkg::ST_PY1: if (stat.eng_done) state_nxt = tgs_pkg::ST_RESULT;
      default: begin
        if (stat.eng_done) state_nxt = tgs_pkg::step_t'(state_r + 1'b1);
      end
    endcase
  end

  // Engine issue tracking
  always_comb begin
    issued_nxt = issued_r;
    if (stat.eng_done)          issued_nxt = 1'b0;
    else if (is_op && !issued_r) issued_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tgs_pkg::ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  // Outputs
  always_comb begin
    is_op          = 1'b1;
    ctrl.op        = tgs_pkg::OP_MUL;
    ctrl.iters     = tgs_pkg::CNT_W'(tgs_pkg::DT_W);
    case (state_r)
      tgs_pkg::ST_IDLE, tgs_pkg::ST_RESULT: is_op = 1'b0;
      tgs_pkg::ST_SQ_X, tgs_pkg::ST_SQ_Y, tgs_pkg::ST_RSQ:
        ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::DIFF_W);
      tgs_pkg::ST_ROOT: begin
        ctrl.op    = tgs_pkg::OP_SQRT;
        ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::ROOT_W);
      end
      tgs_pkg::ST_K0, tgs_pkg::ST_K1:
        ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::MASS_W);
      tgs_pkg::ST_G0, tgs_pkg::ST_G1, tgs_pkg::ST_UX, tgs_pkg::ST_UY: begin
        ctrl.op    = tgs_pkg::OP_DIV;
        ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::G_W);
      end
      tgs_pkg::ST_AX0, tgs_pkg::ST_AY0, tgs_pkg::ST_AX1, tgs_pkg::ST_AY1:
        ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::UNIT_W);
      default: ctrl.iters = tgs_pkg::CNT_W'(tgs_pkg::DT_W);
    endcase
    ctrl.start     = is_op && !issued_r;
    ctrl.step      = state_r;
    ctrl.wb        = stat.eng_done;
    ctrl.in_ready  = (state_r == tgs_pkg::ST_IDLE);
    ctrl.out_valid = (state_r == tgs_pkg::ST_RESULT);
  end

endmodule

@@ hw/rtl/two_body_gravity_step_unit.sv @@
// A load goes straight to the result. A step runs the acceleration operations and then,
// if the time step is in range, the integration; coincident bodies skip the accelerations.
// Each engine operation iterates over its bit count; the longest are the 76-bit divides. One item at a time.
// Reset (rst_n low, synchronous): body state zero, registers to defaults, idle.
// Depends on tgs_pkg, tgs_ifs, tgs_engine, tgs_seq and the assertion header.
`timescale 1ns / 1ps
`include "two_body_gravity_step_unit_assert.svh"

module two_body_gravity_step_unit (
  input  logic   clk,
  input  logic   rst_n,
  tgs_in_if.sink    in_bus,
  tgs_out_if.source out_bus,
  tgs_cfg_if.sink   cfg_bus
);

  localparam int PW = tgs_pkg::POS_W;
  localparam int AW = tgs_pkg::ACC_W;
  localparam int EW = tgs_pkg::ENG_W;
  localparam int BW = tgs_pkg::ENGB_W;
  localparam int MW = EW - tgs_pkg::UNIT_BITS;
  localparam logic [MW-1:0] ACC_POS_LIM = {{(MW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic [MW-1:0] ACC_NEG_LIM = {{(MW-AW){1'b0}}, 1'b1, {(AW-1){1'b0}}};

  // Body state and configuration
  logic signed [PW-1:0] pos_x_r [2];
  logic signed [PW-1:0] pos_y_r [2];
  logic signed [PW-1:0] vel_x_r [2];
  logic signed [PW-1:0] vel_y_r [2];
  logic signed [AW-1:0] acc_x_r [2];
  logic signed [AW-1:0] acc_y_r [2];
  logic [tgs_pkg::GC_W-1:0]   grav_r;
  logic [tgs_pkg::MASS_W-1:0] mass0_r, mass1_r;
  logic [tgs_pkg::LIM_W-1:0]  limit_r;

  // Scratch
  logic [tgs_pkg::SQ_W-1:0]   sq_r, rsq_r;
  logic [tgs_pkg::ROOT_W-1:0] root_r;
  logic [tgs_pkg::K_W-1:0]    k_r;
  logic [tgs_pkg::G_W-1:0]    g0_r, g1_r;
  logic [tgs_pkg::UNIT_W-1:0] ux_r, uy_r;
  logic [tgs_pkg::DT_W-1:0]   dt_r;
  logic coin_r, integ_r, sat_r;

  tgs_pkg::seq_ctrl_t ctrl;
  tgs_pkg::seq_stat_t stat;
  logic               eng_busy, eng_done;
  logic [EW-1:0]      eng_a, eng_res;
  logic [BW-1:0]      eng_b;

  logic                     in_acc, integ_now;
  logic signed [PW:0]       dx, dy;
  logic [PW:0]              ax, ay;
  logic                     acc_neg, acc_over;
  logic [MW-1:0]            acc_mag, acc_lim, acc_clip;
  logic signed [AW-1:0]     acc_val;
  logic signed [PW-1:0]     mv_base, mv_val;
  logic                     mv_vel, mv_sat;
  logic signed [AW:0]       v_sum;
  logic signed [PW:0]       p_sum;

  // Offsets between the bodies
  always_comb begin
    dx = {pos_x_r[1][PW-1], pos_x_r[1]} - {pos_x_r[0][PW-1], pos_x_r[0]};
    dy = {pos_y_r[1][PW-1], pos_y_r[1]} - {pos_y_r[0][PW-1], pos_y_r[0]};
    ax = dx[PW] ? -dx : dx;
    ay = dy[PW] ? -dy : dy;
  end

  assign in_acc    = in_bus.valid && in_bus.ready;
  assign integ_now = (in_bus.time_step != '0) && (in_bus.time_step < limit_r);

  assign stat.accept     = in_acc;
  assign stat.is_step    = (in_bus.command == tgs_pkg::CMD_STEP);
  assign stat.coincident = (dx == '0) && (dy == '0);
  assign stat.integrate  = ctrl.in_ready ? integ_now : integ_r;
  assign stat.eng_done   = eng_done;
  assign stat.out_ready  = out_bus.ready;

  tgs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Engine operand select
  always_comb begin
    eng_a = '0;
    eng_b = '0;
    case (ctrl.step)
      tgs_pkg::ST_SQ_X: begin eng_a = EW'(ax); eng_b = BW'(ax); end
      tgs_pkg::ST_SQ_Y: begin eng_a = EW'(ay); eng_b = BW'(ay); end
      tgs_pkg::ST_ROOT: eng_a = EW'(sq_r);
      tgs_pkg::ST_RSQ:  begin eng_a = EW'(root_r); eng_b = BW'(root_r); end
      tgs_pkg::ST_K0:   begin eng_a = EW'(grav_r); eng_b = BW'(mass1_r); end
      tgs_pkg::ST_K1:   begin eng_a = EW'(grav_r); eng_b = BW'(mass0_r); end
      tgs_pkg::ST_G0, tgs_pkg::ST_G1: begin
        eng_a = EW'({k_r, {(2 * tgs_pkg::FRAC_BITS){1'b0}}});
        eng_b = rsq_r;
      end
      tgs_pkg::ST_UX: begin
        eng_a = EW'({ax, {tgs_pkg::UNIT_BITS{1'b0}}});
        eng_b = BW'(root_r);
      end
      tgs_pkg::ST_UY: begin
        eng_a = EW'({ay, {tgs_pkg::UNIT_BITS{1'b0}}});
        eng_b = BW'(root_r);
      end
      tgs_pkg::ST_AX0: begin eng_a = EW'(g0_r); eng_b = BW'(ux_r); end
      tgs_pkg::ST_AY0: begin eng_a = EW'(g0_r); eng_b = BW'(uy_r); end
      tgs_pkg::ST_AX1: begin eng_a = EW'(g1_r); eng_b = BW'(ux_r); end
      tgs_pkg::ST_AY1: begin eng_a = EW'(g1_r); eng_b = BW'(uy_r); end
      tgs_pkg::ST_VX0: eng_a = {{(EW-AW){acc_x_r[0][AW-1]}}, acc_x_r[0]};
      tgs_pkg::ST_VY0: eng_a = {{(EW-AW){acc_y_r[0][AW-1]}}, acc_y_r[0]};
      tgs_pkg::ST_VX1: eng_a = {{(EW-AW){acc_x_r[1][AW-1]}}, acc_x_r[1]};
      tgs_pkg::ST_VY1: eng_a = {{(EW-AW){acc_y_r[1][AW-1]}}, acc_y_r[1]};
      tgs_pkg::ST_PX0: eng_a = {{(EW-PW){vel_x_r[0][PW-1]}}, vel_x_r[0]};
      tgs_pkg::ST_PY0: eng_a = {{(EW-PW){vel_y_r[0][PW-1]}}, vel_y_r[0]};
      tgs_pkg::ST_PX1: eng_a = {{(EW-PW){vel_x_r[1][PW-1]}}, vel_x_r[1]};
      tgs_pkg::ST_PY1: eng_a = {{(EW-PW){vel_y_r[1][PW-1]}}, vel_y_r[1]};
      default: eng_a = '0;
    endcase
    case (ctrl.step)
      tgs_pkg::ST_VX0, tgs_pkg::ST_VY0, tgs_pkg::ST_VX1, tgs_pkg::ST_VY1,
      tgs_pkg::ST_PX0, tgs_pkg::ST_PY0, tgs_pkg::ST_PX1, tgs_pkg::ST_PY1:
        eng_b = BW'(dt_r);
      default: ;
    endcase
  end

  tgs_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.start),
    .op     (ctrl.op),
    .iters  (ctrl.iters),
    .a_in   (eng_a),
    .b_in   (eng_b),
    .busy   (eng_busy),
    .done   (eng_done),
    .result (eng_res)
  );

  // Acceleration: drop unit fraction, clip, apply direction toward the other body
  always_comb begin
    case (ctrl.step)
      tgs_pkg::ST_AX0: acc_neg = dx[PW];
      tgs_pkg::ST_AY0: acc_neg = dy[PW];
      tgs_pkg::ST_AX1: acc_neg = !dx[PW] && (dx != '0);
      default:         acc_neg = !dy[PW] && (dy != '0);
    endcase
    acc_mag  = eng_res[EW-1:tgs_pkg::UNIT_BITS];
    acc_lim  = acc_neg ? ACC_NEG_LIM : ACC_POS_LIM;
    acc_over = (acc_mag > acc_lim);
    acc_clip = acc_over ? acc_lim : acc_mag;
    acc_val  = acc_neg ? -acc_clip[AW-1:0] : acc_clip[AW-1:0];
  end

  // Motion: floor(product / 2^16) added to velocity or position, clipped to 32 bits
  always_comb begin
    mv_vel = 1'b1;
    case (ctrl.step)
      tgs_pkg::ST_VX0: mv_base = vel_x_r[0];
      tgs_pkg::ST_VY0: mv_base = vel_y_r[0];
      tgs_pkg::ST_VX1: mv_base = vel_x_r[1];
      tgs_pkg::ST_VY1: mv_base = vel_y_r[1];
      tgs_pkg::ST_PX0: begin mv_base = pos_x_r[0]; mv_vel = 1'b0; end
      tgs_pkg::ST_PY0: begin mv_base = pos_y_r[0]; mv_vel = 1'b0; end
      tgs_pkg::ST_PX1: begin mv_base = pos_x_r[1]; mv_vel = 1'b0; end
      default:         begin mv_base = pos_y_r[1]; mv_vel = 1'b0; end
    endcase
    v_sum = {{(AW-PW+1){mv_base[PW-1]}}, mv_base}
          + {eng_res[tgs_pkg::DT_W+AW-1], eng_res[tgs_pkg::DT_W+AW-1:tgs_pkg::DT_W]};
    p_sum = {mv_base[PW-1], mv_base}
          + {eng_res[tgs_pkg::DT_W+PW-1], eng_res[tgs_pkg::DT_W+PW-1:tgs_pkg::DT_W]};
    mv_sat = 1'b0;
    if (mv_vel) begin
      if (v_sum[AW:PW-1] != {(AW-PW+2){v_sum[AW]}}) begin
        mv_sat = 1'b1;
        mv_val = v_sum[AW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
        mv_val = v_sum[PW-1:0];
      end
    end else begin
      if (p_sum[PW] != p_sum[PW-1]) begin
        mv_sat = 1'b1;
        mv_val = p_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
        mv_val = p_sum[PW-1:0];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= tgs_pkg::GRAV_RESET;
      mass0_r <= tgs_pkg::MASS_RESET;
      mass1_r <= tgs_pkg::MASS_RESET;
      limit_r <= tgs_pkg::LIMIT_RESET;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        tgs_pkg::CFG_GRAV_CONST:  grav_r  <= cfg_bus.data[tgs_pkg::GC_W-1:0];
        tgs_pkg::CFG_MASS_FIRST:  mass0_r <= cfg_bus.data[tgs_pkg::MASS_W-1:0];
        tgs_pkg::CFG_MASS_SECOND: mass1_r <= cfg_bus.data[tgs_pkg::MASS_W-1:0];
        tgs_pkg::CFG_STEP_LIMIT:  limit_r <= cfg_bus.data[tgs_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Body state: loads, engine write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        pos_x_r[b] <= '0;
        pos_y_r[b] <= '0;
        vel_x_r[b] <= '0;
        vel_y_r[b] <= '0;
        acc_x_r[b] <= '0;
        acc_y_r[b] <= '0;
      end
      coin_r  <= 1'b0;
      integ_r <= 1'b0;
      sat_r   <= 1'b0;
    end else if (in_acc) begin
      coin_r  <= stat.is_step && stat.coincident;
      integ_r <= stat.is_step && integ_now;
      sat_r   <= 1'b0;
      dt_r    <= in_bus.time_step;
      if (!stat.is_step) begin
        pos_x_r[in_bus.body_select] <= in_bus.load_pos_x;
        pos_y_r[in_bus.body_select] <= in_bus.load_pos_y;
        vel_x_r[in_bus.body_select] <= in_bus.load_vel_x;
        vel_y_r[in_bus.body_select] <= in_bus.load_vel_y;
        acc_x_r[in_bus.body_select] <= in_bus.load_acc_x;
        acc_y_r[in_bus.body_select] <= in_bus.load_acc_y;
      end
    end else if (ctrl.wb) begin
      case (ctrl.step)
        tgs_pkg::ST_SQ_X: sq_r   <= eng_res[tgs_pkg::SQ_W-1:0];
        tgs_pkg::ST_SQ_Y: sq_r   <= sq_r + eng_res[tgs_pkg::SQ_W-1:0];
        tgs_pkg::ST_ROOT: root_r <= eng_res[tgs_pkg::ROOT_W-1:0];
        tgs_pkg::ST_RSQ:  rsq_r  <= eng_res[tgs_pkg::SQ_W-1:0];
        tgs_pkg::ST_K0, tgs_pkg::ST_K1: k_r <= eng_res[tgs_pkg::K_W-1:0];
        tgs_pkg::ST_G0:   g0_r   <= eng_res[tgs_pkg::G_W-1:0];
        tgs_pkg::ST_G1:   g1_r   <= eng_res[tgs_pkg::G_W-1:0];
        tgs_pkg::ST_UX:   ux_r   <= eng_res[tgs_pkg::UNIT_W-1:0];
        tgs_pkg::ST_UY:   uy_r   <= eng_res[tgs_pkg::UNIT_W-1:0];
        tgs_pkg::ST_AX0: begin acc_x_r[0] <= acc_val; sat_r <= sat_r | acc_over; end
        tgs_pkg::ST_AY0: begin acc_y_r[0] <= acc_val; sat_r <= sat_r | acc_over; end
        tgs_pkg::ST_AX1: begin acc_x_r[1] <= acc_val; sat_r <= sat_r | acc_over; end
        tgs_pkg::ST_AY1: begin acc_y_r[1] <= acc_val; sat_r <= sat_r | acc_over; end
        tgs_pkg::ST_VX0: begin vel_x_r[0] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_VY0: begin vel_y_r[0] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_VX1: begin vel_x_r[1] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_VY1: begin vel_y_r[1] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_PX0: begin pos_x_r[0] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_PY0: begin pos_y_r[0] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_PX1: begin pos_x_r[1] <= mv_val; sat_r <= sat_r | mv_sat; end
        tgs_pkg::ST_PY1: begin pos_y_r[1] <= mv_val; sat_r <= sat_r | mv_sat; end
        default: ;
      endcase
    end
  end

  // Ports
  assign in_bus.ready       = ctrl.in_ready;
  assign cfg_bus.ready      = 1'b1;
  assign out_bus.valid      = ctrl.out_valid;
  assign out_bus.first_x    = pos_x_r[0];
  assign out_bus.first_y    = pos_y_r[0];
  assign out_bus.second_x   = pos_x_r[1];
  assign out_bus.second_y   = pos_y_r[1];
  assign out_bus.coincident = coin_r;
  assign out_bus.integrated = integ_r;
  assign out_bus.saturated  = sat_r;

  // Checks
  `TGS_ASSERT(a_idle_engine, in_bus.ready, !eng_busy, "engine busy while accepting beats")
  `TGS_ASSERT_NEXT(a_load_result, in_acc && (in_bus.command == tgs_pkg::CMD_LOAD), out_bus.valid, "load beat did not produce a result next cycle")
  `TGS_ASSERT(a_wb_in_op, ctrl.wb, (ctrl.step != tgs_pkg::ST_IDLE) && (ctrl.step != tgs_pkg::ST_RESULT), "engine finished outside an operation step")
  `TGS_ASSERT(a_integ_gate, ctrl.step == tgs_pkg::ST_VX0, integ_r, "integration entered with time step out of range")

endmodule

@@ dv/tgs_step_checker.sv @@
// Checker for the two-body gravity step unit: watches the item, result and config channels,
// predicts every result from its own copy of the body state and compares beat by beat.
// Depends on tgs_pkg and tgs_ifs.
`timescale 1ns / 1ps

module tgs_step_checker (
  input  logic clk,
  input  logic rst_n,
  tgs_in_if    in_mon,
  tgs_out_if   out_mon,
  tgs_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import tgs_pkg::*;

  typedef struct {
    longint fx, fy, sx, sy;
    bit     coin, integ, sat;
  } positions_t;

  positions_t expected_q[$];

  // body state and register copies
  longint pos_x[2], pos_y[2], vel_x[2], vel_y[2], acc_x[2], acc_y[2];
  logic [GC_W-1:0]   grav;
  logic [MASS_W-1:0] mass0, mass1;
  logic [LIM_W-1:0]  dt_limit;
  bit                clipped;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // floor sqrt of a value below 2^66, two bits per pass
  function automatic logic [127:0] floor_sqrt(logic [127:0] v);
    logic [127:0] root, rem, trial;
    root = '0;
    rem  = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint pull_component(logic [127:0] g, logic [127:0] u, bit neg);
    logic [127:0] mag, lim;
    logic [47:0]  m48;
    if (u == '0) return 0;
    mag = (g * u) >> UNIT_BITS;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (mag > lim) begin
      clipped = 1'b1;
      mag = lim;
    end
    m48 = neg ? -mag[47:0] : mag[47:0];
    return longint'($signed(m48));
  endfunction

  function automatic void move_body(int b, longint dt);
    vel_x[b] = clip32(vel_x[b] + ((acc_x[b] * dt) >>> 16));
    vel_y[b] = clip32(vel_y[b] + ((acc_y[b] * dt) >>> 16));
    pos_x[b] = clip32(pos_x[b] + ((vel_x[b] * dt) >>> 16));
    pos_y[b] = clip32(pos_y[b] + ((vel_y[b] * dt) >>> 16));
  endfunction

  // one step command: forces, then motion if the frame time is in range
  function automatic positions_t run_step(logic [DT_W-1:0] dt_in);
    positions_t   r;
    longint       dx, dy, dt;
    logic [127:0] ax, ay, root, ux, uy, g0, g1;
    clipped = 1'b0;
    r.coin  = 1'b0;
    r.integ = 1'b0;
    dx = pos_x[1] - pos_x[0];
    dy = pos_y[1] - pos_y[0];
    dt = longint'(dt_in);
    if (dx == 0 && dy == 0) begin
      r.coin = 1'b1;
    end else begin
      ax   = 128'(dx < 0 ? -dx : dx);
      ay   = 128'(dy < 0 ? -dy : dy);
      root = floor_sqrt(ax * ax + ay * ay);
      ux   = (ax << UNIT_BITS) / root;
      uy   = (ay << UNIT_BITS) / root;
      g0   = (((128'(grav) * 128'(mass1)) << (2 * FRAC_BITS)) / root) / root;
      g1   = (((128'(grav) * 128'(mass0)) << (2 * FRAC_BITS)) / root) / root;
      acc_x[0] = pull_component(g0, ux, dx < 0);
      acc_y[0] = pull_component(g0, uy, dy < 0);
      acc_x[1] = pull_component(g1, ux, dx > 0);
      acc_y[1] = pull_component(g1, uy, dy > 0);
    end
    if (dt > 0 && dt < longint'(dt_limit)) begin
      r.integ = 1'b1;
      move_body(0, dt);
      move_body(1, dt);
    end
    r.sat = clipped;
    return r;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    positions_t r;
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        pos_x[b] = 0; pos_y[b] = 0; vel_x[b] = 0;
        vel_y[b] = 0; acc_x[b] = 0; acc_y[b] = 0;
      end
      grav       = GRAV_RESET;
      mass0      = MASS_RESET;
      mass1      = MASS_RESET;
      dt_limit   = LIMIT_RESET;
      fail_count = 0;
      expected_q.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_GRAV_CONST:  grav     = cfg_mon.data[GC_W-1:0];
          CFG_MASS_FIRST:  mass0    = cfg_mon.data[MASS_W-1:0];
          CFG_MASS_SECOND: mass1    = cfg_mon.data[MASS_W-1:0];
          CFG_STEP_LIMIT:  dt_limit = cfg_mon.data[LIM_W-1:0];
          default: ;
        endcase
      end
      // item beat
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          pos_x[in_mon.body_select] = longint'(in_mon.load_pos_x);
          pos_y[in_mon.body_select] = longint'(in_mon.load_pos_y);
          vel_x[in_mon.body_select] = longint'(in_mon.load_vel_x);
          vel_y[in_mon.body_select] = longint'(in_mon.load_vel_y);
          acc_x[in_mon.body_select] = longint'(in_mon.load_acc_x);
          acc_y[in_mon.body_select] = longint'(in_mon.load_acc_y);
          r.coin  = 1'b0;
          r.integ = 1'b0;
          r.sat   = 1'b0;
        end else begin
          r = run_step(in_mon.time_step);
        end
        r.fx = pos_x[0];
        r.fy = pos_y[0];
        r.sx = pos_x[1];
        r.sy = pos_y[1];
        expected_q.push_back(r);
      end
      // result beat
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat: expected none actual first_x %0d",
                   $time, out_mon.first_x);
        end else begin
          r = expected_q.pop_front();
          check_field("first_x", r.fx, longint'(out_mon.first_x));
          check_field("first_y", r.fy, longint'(out_mon.first_y));
          check_field("second_x", r.sx, longint'(out_mon.second_x));
          check_field("second_y", r.sy, longint'(out_mon.second_y));
          check_field("coincident", longint'(r.coin), longint'(out_mon.coincident));
          check_field("integrated", longint'(r.integ), longint'(out_mon.integrated));
          check_field("saturated", longint'(r.sat), longint'(out_mon.saturated));
        end
      end
    end
    // beats accepted but not yet answered
    pending = expected_q.size();
  end

endmodule

@@ dv/tb_two_body_gravity_step_unit.sv @@
// Testbench top for the two-body gravity step unit: clock, reset, load/step stimulus,
// register phases and the verdict. Depends on tgs_pkg, tgs_ifs and tgs_step_checker.
`timescale 1ns / 1ps

module tb_two_body_gravity_step_unit;
  import tgs_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   no_gaps;

  tgs_in_if  in_bus();
  tgs_out_if out_bus();
  tgs_cfg_if cfg_bus();

  two_body_gravity_step_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  tgs_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  // result side stalls
  initial begin
    int gap;
    out_bus.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_bus.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  // valid stays high across back-to-back beats
  task automatic send_item(logic cmd, logic sel, logic [31:0] px, logic [31:0] py,
                           logic [31:0] vx, logic [31:0] vy, logic [47:0] ax,
                           logic [47:0] ay, logic [15:0] dt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1;
    in_bus.command     <= cmd;
    in_bus.body_select <= sel;
    in_bus.load_pos_x  <= px;
    in_bus.load_pos_y  <= py;
    in_bus.load_vel_x  <= vx;
    in_bus.load_vel_y  <= vy;
    in_bus.load_acc_x  <= ax;
    in_bus.load_acc_y  <= ay;
    in_bus.time_step   <= dt;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic step(logic [15:0] dt);
    send_item(CMD_STEP, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
              48'({$urandom, $urandom}), 48'({$urandom, $urandom}), dt);
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 0;
    @(posedge clk);
  endtask

  // positions mostly moderate so forces stay meaningful, sometimes full range
  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return 0;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [47:0] pick_acc();
    case ($urandom_range(0, 3))
      0:       return 48'({$urandom, $urandom});
      1:       return $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      default: return {{24{1'b0}}, 24'($urandom)} - 48'h80_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 6553));
    endcase
  endfunction

  task automatic load_body(logic sel);
    send_item(CMD_LOAD, sel, pick_pos(), pick_pos(), pick_vel(), pick_vel(),
              pick_acc(), pick_acc(), 16'($urandom));
  endtask

  // mostly load-both-then-step sequences, some stray loads and lone steps
  task automatic random_phase(int n_items);
    int sent, n_steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      case ($urandom_range(0, 9))
        0: begin
          load_body(1'($urandom_range(0, 1)));
          sent++;
        end
        1: begin
          step(pick_dt());
          sent++;
        end
        default: begin
          load_body(1'b0);
          load_body(1'b1);
          n_steps = $urandom_range(1, 6);
          repeat (n_steps) step(pick_dt());
          sent += 2 + n_steps;
        end
      endcase
    end
  endtask

  task automatic set_regs(logic [23:0] g, logic [23:0] m0, logic [23:0] m1,
                          logic [23:0] lim);
    drain();
    write_reg(CFG_GRAV_CONST, g);
    write_reg(CFG_MASS_FIRST, m0);
    write_reg(CFG_MASS_SECOND, m1);
    write_reg(CFG_STEP_LIMIT, lim);
  endtask

  initial begin
    in_bus.valid       = 0;
    in_bus.command     = CMD_LOAD;
    in_bus.body_select = 0;
    in_bus.load_pos_x  = 0;
    in_bus.load_pos_y  = 0;
    in_bus.load_vel_x  = 0;
    in_bus.load_vel_y  = 0;
    in_bus.load_acc_x  = 0;
    in_bus.load_acc_y  = 0;
    in_bus.time_step   = 0;
    cfg_bus.valid      = 0;
    cfg_bus.index      = 0;
    cfg_bus.data       = 0;
    no_gaps            = 0;
    rst_n              = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset defaults, coincident bodies at reset, loads at extremes
    step(16'd100);
    send_item(CMD_LOAD, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 16'hFFFF);
    send_item(CMD_LOAD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 16'h0000);
    step(16'd6553);
    step(16'd0);
    step(16'd6554);
    send_item(CMD_LOAD, 1'b0, 0, 0, 32'h0001_0000, 0, 0, 0, 0);
    send_item(CMD_LOAD, 1'b1, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 0, 0);
    step(16'd1);
    step(16'd3000);
    send_item(CMD_LOAD, 1'b1, 0, 0, 0, 0, 48'h0000_0001_0000, 48'hFFFF_FFFF_0000, 0);
    send_item(CMD_LOAD, 1'b0, 0, 0, 0, 0, 48'h0000_0002_0000, 0, 0);
    step(16'd5000);
    send_item(CMD_LOAD, 1'b0, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    step(16'd2);
    random_phase(100);

    // no gravity, widest time step window; stray index is ignored
    set_regs(24'd0, 24'd1, 24'd1, 24'hFFFF);
    write_reg(8'd4, 24'($urandom));
    write_reg(8'hFF, 24'($urandom));
    step(16'hFFFE);
    step(16'hFFFF);
    random_phase(80);

    // strongest pull
    set_regs(24'hFF_FFFF, 24'hF_FFFF, 24'hF_FFFF, 24'hFFFF);
    random_phase(80);

    // integration never happens
    set_regs(24'd1000, 24'd1, 24'hF_FFFF, 24'd1);
    step(16'd0);
    step(16'd1);
    random_phase(60);

    // random register set, then back to defaults
    set_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    random_phase(80);
    set_regs(24'(GRAV_RESET), 24'(MASS_RESET), 24'(MASS_RESET), 24'(LIMIT_RESET));
    random_phase(80);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
